// ----- rtl/hbt_pkg.sv -----
package hbt_pkg;

    localparam int MAX_BUCKETS      = 64;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int SLOT_TOTAL       = MAX_BUCKETS * SLOTS_PER_BUCKET;

    localparam int BUCKET_W    = $clog2(MAX_BUCKETS);
    localparam int SLOT_IDX_W  = $clog2(SLOTS_PER_BUCKET);
    localparam int SLOT_ADDR_W = BUCKET_W + SLOT_IDX_W;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 31;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 10;
    localparam int BCOUNT_W = 7;

    localparam logic [BCOUNT_W-1:0]   BUCKET_COUNT_RESET = BCOUNT_W'(10);
    localparam logic [SLOT_IDX_W-1:0] LAST_SLOT          = SLOT_IDX_W'(SLOTS_PER_BUCKET - 1);

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic [KEY_W-1:0]         key;
        logic signed [DATA_W-1:0] data_in;
    } hbt_request_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] data_out;
        logic                     bucket_full;
        logic [COUNT_W-1:0]       entry_total;
    } hbt_result_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } slot_entry_t;

    typedef struct packed {
        logic                   en;
        logic [SLOT_ADDR_W-1:0] addr;
        slot_entry_t            entry;
    } slot_wr_t;

    typedef struct packed {
        logic                        en;
        logic [BUCKET_W-1:0]         addr;
        logic [SLOTS_PER_BUCKET-1:0] mask;
    } mask_wr_t;

endpackage

// ----- rtl/bucketed_hash_table_unit.sv -----
// Key-value store of 64 buckets with 8 slots each. A transaction on req is
// an insert or update, a search or a remove; its bucket is the key modulo
// the bucket count written on cfg_wen/cfg_wdata (reset 10, zero reads as
// one, values above 64 as 64). Every request returns one transaction on rsp
// with hit, the found value on a search, the bucket-full flag of a rejected
// insert and the entry count after the request. Requests run one at a time:
// req_ready is low from acceptance until the result is loaded into rsp. A
// request passes through the two-bits-per-cycle remainder unit, which then
// hands over the bucket, a read of the slot memory, one slot per cycle across
// the 8 slots of the bucket, and a last step that writes back and loads the
// result. A finished result waits in the rsp register while the next request
// runs; if it is still waiting when that request finishes, the request holds
// until rsp is taken.
// Slot valid marks are held per bucket and read as empty after reset, so no
// clearing pass is needed. Write cfg only while no request is in flight.
module bucketed_hash_table_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [hbt_pkg::BCOUNT_W-1:0] cfg_wdata,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  hbt_pkg::hbt_request_t        req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output hbt_pkg::hbt_result_t         rsp
);
    import hbt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    hbt_request_t            req_reg, req_next;
    logic [BCOUNT_W-1:0]     bcount_reg, bcount_next;
    logic [BUCKET_W-1:0]     bucket_reg, bucket_next;
    logic [SLOT_IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                    found_reg, found_next;
    logic [SLOT_IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic [DATA_W-1:0]       found_data_reg, found_data_next;
    logic                    free_ok_reg, free_ok_next;
    logic [SLOT_IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    hbt_result_t             rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    logic [BCOUNT_W-1:0]         divisor;
    logic                        div_start;
    logic                        div_done;
    logic [BUCKET_W-1:0]         div_rem;
    logic                        rd_en;
    logic [SLOT_ADDR_W-1:0]      slot_rd_addr;
    logic                        mask_rd_en;
    slot_entry_t                 slot_rd;
    logic [SLOTS_PER_BUCKET-1:0] mask_rd;
    logic [SLOTS_PER_BUCKET-1:0] sel_found;
    logic [SLOTS_PER_BUCKET-1:0] sel_free;
    slot_wr_t                    slot_wr;
    mask_wr_t                    mask_wr;

    always_comb
    begin
        if (bcount_reg == '0)
        begin
            divisor = BCOUNT_W'(1);
        end
        else if (bcount_reg > BCOUNT_W'(MAX_BUCKETS))
        begin
            divisor = BCOUNT_W'(MAX_BUCKETS);
        end
        else
        begin
            divisor = bcount_reg;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign div_start = req_valid && req_ready;
    assign sel_found = SLOTS_PER_BUCKET'(1) << found_idx_reg;
    assign sel_free  = SLOTS_PER_BUCKET'(1) << free_idx_reg;

    hbt_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req.key),
        .divisor   (divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    hbt_slot_store u_slots (
        .clk      (clk),
        .wr       (slot_wr),
        .rd_en    (rd_en),
        .rd_addr  (slot_rd_addr),
        .rd_entry (slot_rd)
    );

    hbt_mask_store u_masks (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mask_wr),
        .rd_en   (mask_rd_en),
        .rd_addr (div_rem),
        .rd_mask (mask_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        bcount_next     = cfg_wen ? cfg_wdata : bcount_reg;
        bucket_next     = bucket_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_data_next = found_data_reg;
        free_ok_next    = free_ok_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rd_en           = 1'b0;
        slot_rd_addr    = {bucket_reg, cmp_idx_reg + SLOT_IDX_W'(1)};
        mask_rd_en      = 1'b0;
        slot_wr         = '0;
        mask_wr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (div_start)
                begin
                    req_next   = req;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    bucket_next  = div_rem;
                    mask_rd_en   = 1'b1;
                    rd_en        = 1'b1;
                    slot_rd_addr = {div_rem, SLOT_IDX_W'(0)};
                    cmp_idx_next = '0;
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (mask_rd[cmp_idx_reg] && slot_rd.key == req_reg.key && !found_reg)
                begin
                    found_next      = 1'b1;
                    found_idx_next  = cmp_idx_reg;
                    found_data_next = slot_rd.data;
                end
                if (!mask_rd[cmp_idx_reg] && !free_ok_reg)
                begin
                    free_ok_next  = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
                if (cmp_idx_reg != LAST_SLOT)
                begin
                    rd_en        = 1'b1;
                    cmp_idx_next = cmp_idx_reg + SLOT_IDX_W'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next = '0;
                    case (req_reg.action)
                        ACT_INSERT:
                        begin
                            if (found_reg)
                            begin
                                slot_wr.en    = 1'b1;
                                slot_wr.addr  = {bucket_reg, found_idx_reg};
                                slot_wr.entry = {req_reg.key, req_reg.data_in};
                                rsp_next.hit  = 1'b1;
                            end
                            else if (free_ok_reg)
                            begin
                                slot_wr.en    = 1'b1;
                                slot_wr.addr  = {bucket_reg, free_idx_reg};
                                slot_wr.entry = {req_reg.key, req_reg.data_in};
                                mask_wr.en    = 1'b1;
                                mask_wr.addr  = bucket_reg;
                                mask_wr.mask  = mask_rd | sel_free;
                                count_next    = count_reg + COUNT_W'(1);
                            end
                            else
                            begin
                                rsp_next.bucket_full = 1'b1;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (found_reg)
                            begin
                                rsp_next.hit      = 1'b1;
                                rsp_next.data_out = found_data_reg;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                mask_wr.en   = 1'b1;
                                mask_wr.addr = bucket_reg;
                                mask_wr.mask = mask_rd & ~sel_found;
                                rsp_next.hit = 1'b1;
                                if (count_reg != '0)
                                begin
                                    count_next = count_reg - COUNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.entry_total = count_next;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bcount_reg    <= BUCKET_COUNT_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            free_ok_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bcount_reg    <= bcount_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            found_reg     <= found_next;
            free_ok_reg   <= free_ok_next;
            cmp_idx_reg   <= cmp_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        bucket_reg     <= bucket_next;
        found_idx_reg  <= found_idx_next;
        found_data_reg <= found_data_next;
        free_idx_reg   <= free_idx_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/hbt_divider.sv -----
module hbt_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [hbt_pkg::KEY_W-1:0]    dividend,
    input  logic [hbt_pkg::BCOUNT_W-1:0] divisor,
    output logic                         done,
    output logic [hbt_pkg::BUCKET_W-1:0] remainder
);
    import hbt_pkg::*;

    localparam int DVD_W = KEY_W + (KEY_W % 2);
    localparam int STEPS = DVD_W / 2;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [BCOUNT_W-1:0] div_reg;
    logic [BCOUNT_W-1:0] rem_reg;
    logic [BCOUNT_W-1:0] rem_one;
    logic [BCOUNT_W-1:0] rem_two;

    function automatic logic [BCOUNT_W-1:0] rem_step(
        input logic [BCOUNT_W-1:0] r,
        input logic                b,
        input logic [BCOUNT_W-1:0] d
    );
        logic [BCOUNT_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[BCOUNT_W-1:0];
    endfunction

    assign rem_one = rem_step(rem_reg, dvd_reg[DVD_W-1], div_reg);
    assign rem_two = rem_step(rem_one, dvd_reg[DVD_W-2], div_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DVD_W'(dividend);
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 2;
            rem_reg <= rem_two;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[BUCKET_W-1:0];

endmodule

// ----- rtl/hbt_slot_store.sv -----
module hbt_slot_store (
    input  logic                            clk,
    input  hbt_pkg::slot_wr_t               wr,
    input  logic                            rd_en,
    input  logic [hbt_pkg::SLOT_ADDR_W-1:0] rd_addr,
    output hbt_pkg::slot_entry_t            rd_entry
);
    import hbt_pkg::*;

    slot_entry_t mem [SLOT_TOTAL];
    slot_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ----- rtl/hbt_mask_store.sv -----
module hbt_mask_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hbt_pkg::mask_wr_t                    wr,
    input  logic                                 rd_en,
    input  logic [hbt_pkg::BUCKET_W-1:0]         rd_addr,
    output logic [hbt_pkg::SLOTS_PER_BUCKET-1:0] rd_mask
);
    import hbt_pkg::*;

    logic [SLOTS_PER_BUCKET-1:0] mem [MAX_BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0] rd_mask_reg;
    logic [MAX_BUCKETS-1:0]      row_ok_reg;
    logic                        rd_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_ok_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= row_ok_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.mask;
        end
        if (rd_en)
        begin
            rd_mask_reg <= mem[rd_addr];
        end
    end

    assign rd_mask = rd_ok_reg ? rd_mask_reg : '0;

endmodule
